/* hw/rtl/afdit_pkg.sv */
// Shared types, constants and drain-rate tables for the audio FIFO drain timer.
package afdit_pkg;

  localparam int unsigned CtrlWidth = 16;
  localparam int unsigned FracWidth = 17;
  localparam int unsigned StepWidth = 16;
  localparam int unsigned LineWidth = 32;

  localparam logic [CtrlWidth-1:0] IrqEnableMask   = 16'h4003;
  localparam logic [LineWidth-1:0] IrqPeriodLines  = 32'd200;
  localparam int unsigned          IrqLevelThresh  = 12;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PUSH = 1'b1
  } op_t;

  typedef enum logic {
    REG_CONTROL = 1'b0,
    REG_PAL     = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [LineWidth-1:0] line_count;
    logic [LineWidth-1:0] last_irq_line;
  } timer_state_t;

  // 0.16 bytes-per-line drain step, rate << 16 divided by 60, 262, 2 in turn
  localparam logic [StepWidth-1:0] NtscStep [8] = '{
    16'd16675, 16'd29182, 16'd25013, 16'd29182,
    16'd33351, 16'd37520, 16'd33351, 16'd33351
  };

  // 0.16 bytes-per-line drain step, rate << 16 divided by 50, 312, 2 in turn
  localparam logic [StepWidth-1:0] PalStep [8] = '{
    16'd16804, 16'd29407, 16'd25206, 16'd29407,
    16'd33608, 16'd37809, 16'd33608, 16'd33608
  };

  function automatic logic [StepWidth-1:0] drain_step(input logic [2:0] sel, input logic pal);
    drain_step = pal ? PalStep[sel] : NtscStep[sel];
  endfunction

endpackage

/* hw/rtl/audio_fifo_drain_irq_timer.sv */
// Top level of the audio FIFO drain and level-3 interrupt timer.
//
// Input channel (in_valid/in_ready): one beat per event; op selects a video
// line tick or a FIFO push of push_bytes bytes.
// Output channel (out_valid/out_ready): one beat per input beat, carrying
// irq_request and the FIFO level after the event, in input order.
// Configuration: cfg_wen writes cfg_wdata to register cfg_index at the clock
// edge (0 = control word, 1 = PAL mode); write only while the block is idle.
// An accepted beat's result is registered in the output or skid register.
// Throughput: one beat per cycle while in_ready is high, set by the single
// combinational step from the state registers into the output register.
// Stall: a result that is not taken is held; one more beat is taken into a
// skid register, after which in_ready drops until the output drains.
// Reset (rst, synchronous): line counters, FIFO level, drain fraction and
// configuration clear; both output registers empty.
module audio_fifo_drain_irq_timer
  import afdit_pkg::*;
#(
  parameter int unsigned FIFO_CAPACITY = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  op,
  input  logic [7:0]                            push_bytes,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  irq_request,
  output logic [$clog2(FIFO_CAPACITY+1)-1:0]    fifo_level,
  input  logic                                  cfg_wen,
  input  logic                                  cfg_index,
  input  logic [CtrlWidth-1:0]                  cfg_wdata
);

  localparam int unsigned LevelWidth = $clog2(FIFO_CAPACITY+1);

  logic [CtrlWidth-1:0]  control_word;
  logic                  pal_mode;
  timer_state_t          timer;
  timer_state_t          timer_next;
  logic [LevelWidth-1:0] level_now;
  logic [LevelWidth-1:0] level_now_next;
  logic [LevelWidth-1:0] level_before;
  logic [LevelWidth-1:0] level_before_next;
  logic [FracWidth-1:0]  drain_fraction;
  logic [FracWidth-1:0]  drain_fraction_next;
  logic                  irq;

  logic                  skid_valid;
  logic                  skid_irq;
  logic [LevelWidth-1:0] skid_level;
  logic                  accept;
  logic                  take;

  afdit_step #(
    .FIFO_CAPACITY (FIFO_CAPACITY),
    .LevelWidth    (LevelWidth)
  ) u_step (
    .op                  (op),
    .push_bytes          (push_bytes),
    .control_word        (control_word),
    .pal_mode            (pal_mode),
    .timer               (timer),
    .level_now           (level_now),
    .level_before        (level_before),
    .drain_fraction      (drain_fraction),
    .timer_next          (timer_next),
    .level_now_next      (level_now_next),
    .level_before_next   (level_before_next),
    .drain_fraction_next (drain_fraction_next),
    .irq                 (irq)
  );

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign take     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_word <= '0;
      pal_mode     <= 1'b0;
    end else if (cfg_wen) begin
      unique case (reg_index_t'(cfg_index))
        REG_CONTROL: control_word <= cfg_wdata;
        REG_PAL:     pal_mode     <= cfg_wdata[0];
        default:     control_word <= control_word;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer          <= '0;
      level_now      <= '0;
      level_before   <= '0;
      drain_fraction <= '0;
    end else if (accept) begin
      timer          <= timer_next;
      level_now      <= level_now_next;
      level_before   <= level_before_next;
      drain_fraction <= drain_fraction_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || take) begin
        if (skid_valid) begin
          out_valid   <= 1'b1;
          irq_request <= skid_irq;
          fifo_level  <= skid_level;
          skid_valid  <= 1'b0;
        end else begin
          out_valid   <= accept;
          irq_request <= irq;
          fifo_level  <= level_now_next;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
        skid_irq   <= irq;
        skid_level <= level_now_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full with output register empty");

  a_level_bounded: assert property (@(posedge clk) disable iff (rst)
    level_now <= LevelWidth'(FIFO_CAPACITY))
    else $error("FIFO level above capacity");

  a_fraction_below_one: assert property (@(posedge clk) disable iff (rst)
    !drain_fraction[FracWidth-1])
    else $error("drain fraction holds a whole byte");

  a_push_no_irq: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_PUSH)) |-> !irq)
    else $error("push beat raised an interrupt");
`endif

endmodule

/* hw/rtl/afdit_step.sv */
// Next-state and result logic for one tick or push beat.
module afdit_step
  import afdit_pkg::*;
#(
  parameter int unsigned FIFO_CAPACITY = 1024,
  parameter int unsigned LevelWidth    = 11
) (
  input  logic                  op,
  input  logic [7:0]            push_bytes,
  input  logic [CtrlWidth-1:0]  control_word,
  input  logic                  pal_mode,
  input  timer_state_t          timer,
  input  logic [LevelWidth-1:0] level_now,
  input  logic [LevelWidth-1:0] level_before,
  input  logic [FracWidth-1:0]  drain_fraction,
  output timer_state_t          timer_next,
  output logic [LevelWidth-1:0] level_now_next,
  output logic [LevelWidth-1:0] level_before_next,
  output logic [FracWidth-1:0]  drain_fraction_next,
  output logic                  irq
);

  localparam logic [LevelWidth:0]   CapacityExt = (LevelWidth+1)'(FIFO_CAPACITY);
  localparam logic [LevelWidth-1:0] Threshold   = LevelWidth'(IrqLevelThresh);

  logic [LevelWidth:0]   push_sum;
  logic [LineWidth-1:0]  line_inc;
  logic [LineWidth-1:0]  elapsed;
  logic                  periodic;
  logic [FracWidth-1:0]  frac_sum;
  logic [LevelWidth-1:0] drained;

  always_comb begin
    push_sum = {1'b0, level_now} + (LevelWidth+1)'(push_bytes);
    line_inc = timer.line_count + LineWidth'(1);
    elapsed  = line_inc - timer.last_irq_line;
    periodic = ((control_word & IrqEnableMask) != '0) && (elapsed > IrqPeriodLines);
    frac_sum = drain_fraction + FracWidth'(drain_step(control_word[2:0], pal_mode));

    timer_next          = timer;
    level_now_next      = level_now;
    level_before_next   = level_before;
    drain_fraction_next = drain_fraction;
    irq                 = 1'b0;
    drained             = level_now;

    if (op == OP_PUSH) begin
      level_now_next = (push_sum > CapacityExt) ? CapacityExt[LevelWidth-1:0]
                                                : push_sum[LevelWidth-1:0];
    end else begin
      timer_next.line_count = line_inc;
      if (periodic) begin
        timer_next.last_irq_line = line_inc;
        irq                      = 1'b1;
      end else begin
        if (level_now != '0) begin
          drain_fraction_next = frac_sum;
          if (frac_sum[FracWidth-1]) begin
            drain_fraction_next = {1'b0, frac_sum[FracWidth-2:0]};
            drained             = level_now - LevelWidth'(1);
          end
        end else begin
          drain_fraction_next = '0;
        end
        level_now_next    = drained;
        level_before_next = drained;
        if ((level_before >= Threshold) && (drained < Threshold)) begin
          timer_next.last_irq_line = line_inc;
          irq                      = 1'b1;
        end
      end
    end
  end

endmodule
